>>> sv/fbpa_pkg.sv
// shared constants, codes and types of the fixed block pool allocator
// no dependencies; every other file but fbpa_ram uses it

package fbpa_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 17;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int PROD_W     = IDX_W + SIZE_W;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = 32'd4096;
   localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd8;
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
   localparam logic [SIZE_W-1:0]  LINK_WORD_BYTES = 17'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_NULL  = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_status_type;

endpackage

>>> sv/fbpa_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on fbpa_pkg for field widths and the status type

interface fbpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [fbpa_pkg::ADDR_W-1:0] block_address;

   modport source (output valid, req_type, block_address, input ready);
   modport sink   (input valid, req_type, block_address, output ready);
endinterface

interface fbpa_rsp_if;
   logic                         valid;
   logic                         ready;
   fbpa_pkg::status_type         status;
   logic [fbpa_pkg::ADDR_W-1:0]  granted_address;
   logic [fbpa_pkg::COUNT_W-1:0] free_blocks;
   logic [fbpa_pkg::COUNT_W-1:0] total_blocks;

   modport source (output valid, status, granted_address, free_blocks, total_blocks,
                   input ready);
   modport sink   (input valid, status, granted_address, free_blocks, total_blocks,
                   output ready);
endinterface

>>> sv/fbpa_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fbpa_div.sv
// serial restoring divider, one quotient bit per cycle, for the block index
// depends on fbpa_pkg for widths and the status struct

module fbpa_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fbpa_pkg::ADDR_W-1:0]     dividend,
   input  logic [fbpa_pkg::SIZE_W-1:0]     divisor,
   output fbpa_pkg::div_status_type        div_st
);
   import fbpa_pkg::*;

   localparam int STEP_W = $clog2(ADDR_W);

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [ADDR_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   shifted;
   logic [SIZE_W:0]   diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[ADDR_W-1]};
      fits    = shifted >= {1'b0, divisor};
      diff    = shifted - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
         quo_in  = {quo_ff[ADDR_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(ADDR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_st.done      = done_ff;
   assign div_st.quotient  = quo_ff;
   assign div_st.remainder = rem_ff;

endmodule

>>> sv/fixed_block_pool_allocator_core.sv
// top level of the fixed block pool allocator: config registers, free list control
// depends on fbpa_pkg, fbpa_if, fbpa_ram and fbpa_div
//
//   channel  | direction | handshake       | payload
//   req_chan | in        | valid / ready   | req_type, block_address
//   rsp_chan | out       | valid / ready   | status, granted_address, free_blocks,
//            |           |                 | total_blocks
//   csr_*    | in        | write enable    | csr_index, csr_write_data
//
// allocate, empty, null and below-base transactions go from accept to S_DONE
// any other free first runs the 32-step serial divider that finds the block index
// reset and every write to a used register start a pass over the link memory;
// req ready stays low until it ends
// one transaction at a time; a new one is accepted while the output register holds
// a result, and it finishes once that register is free

module fixed_block_pool_allocator_core (
   input  logic                             clock,
   input  logic                             reset,
   fbpa_req_if.sink                         req_chan,
   fbpa_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]      csr_write_data
);
   import fbpa_pkg::*;

   logic [ADDR_W-1:0]  pool_base_ff;
   logic [SIZE_W-1:0]  block_size_ff;
   logic [COUNT_W-1:0] block_count_ff;
   logic [COUNT_W-1:0] n_eff;
   logic [SIZE_W-1:0]  bs_eff;
   logic               csr_hit;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [IDX_W:0]     clr_next;
   req_kind_type       kind_ff, kind_in;
   status_type         status_ff, status_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [ADDR_W-1:0]  out_granted_ff, out_granted_in;
   logic [COUNT_W-1:0] out_free_ff, out_free_in;
   logic [COUNT_W-1:0] out_total_ff, out_total_in;
   logic               out_slot_free;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [IDX_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_data;

   logic               div_start;
   div_status_type     div_st;
   logic               index_ok;

   // effective configuration
   always_comb begin
      n_eff = block_count_ff;
      if (block_count_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (block_count_ff > COUNT_W'(MAX_BLOCKS)) begin
         n_eff = COUNT_W'(MAX_BLOCKS);
      end
      bs_eff = (block_size_ff < LINK_WORD_BYTES) ? LINK_WORD_BYTES : block_size_ff;
   end

   assign csr_hit = csr_write_enable && (csr_index == CSR_POOL_BASE ||
                                         csr_index == CSR_BLOCK_SIZE ||
                                         csr_index == CSR_BLOCK_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= POOL_BASE_RST;
         block_size_ff  <= BLOCK_SIZE_RST;
         block_count_ff <= BLOCK_COUNT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POOL_BASE:   pool_base_ff   <= csr_write_data;
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_BLOCK_COUNT: block_count_ff <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   fbpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_chan.block_address - pool_base_ff),
      .divisor  (bs_eff),
      .div_st   (div_st)
   );

   assign out_slot_free = !out_valid_ff || rsp_chan.ready;
   assign clr_next      = {1'b0, clr_cnt_ff} + 1'b1;
   assign index_ok      = (div_st.remainder == '0) &&
                          (div_st.quotient < ADDR_W'(n_eff));
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      free_in        = free_ff;
      clr_cnt_in     = clr_cnt_ff;
      kind_in        = kind_ff;
      status_in      = status_ff;
      prod_in        = prod_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_status_in  = out_status_ff;
      out_granted_in = out_granted_ff;
      out_free_in    = out_free_ff;
      out_total_in   = out_total_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clr_cnt_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      div_start      = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // link entry i to i+1, last used entry and those beyond it to zero
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = (clr_next < (IDX_W+1)'(n_eff)) ? clr_next[IDX_W-1:0] : '0;
            head_in     = '0;
            free_in     = n_eff;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(MAX_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in = req_kind_type'(req_chan.req_type);
               if (req_chan.req_type == REQ_ALLOC) begin
                  if (free_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     status_in = ST_OK;
                     ram_rd_en = 1'b1;
                     prod_in   = PROD_W'(head_ff) * PROD_W'(bs_eff);
                  end
                  state_in = S_DONE;
               end else if (req_chan.block_address == '0) begin
                  status_in = ST_NULL;
                  state_in  = S_DONE;
               end else if (req_chan.block_address < pool_base_ff) begin
                  status_in = ST_BAD;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_st.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_slot_free) begin
               out_valid_in   = 1'b1;
               out_status_in  = status_ff;
               out_granted_in = '0;
               out_free_in    = free_ff;
               out_total_in   = n_eff;
               if (status_ff == ST_OK) begin
                  if (kind_ff == REQ_ALLOC) begin
                     // pop the head
                     head_in        = ram_rd_data;
                     free_in        = free_ff - 1'b1;
                     out_free_in    = free_ff - 1'b1;
                     out_granted_in = pool_base_ff + ADDR_W'(prod_ff);
                  end else if (!index_ok) begin
                     out_status_in = ST_BAD;
                  end else begin
                     // push at the head
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = div_st.quotient[IDX_W-1:0];
                     ram_wr_data = head_ff;
                     head_in     = div_st.quotient[IDX_W-1:0];
                     if (free_ff < n_eff) begin
                        free_in     = free_ff + 1'b1;
                        out_free_in = free_ff + 1'b1;
                     end
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      if (csr_hit) begin
         state_in   = S_CLEAR;
         clr_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         head_ff      <= '0;
         free_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff        <= kind_in;
      status_ff      <= status_in;
      prod_ff        <= prod_in;
      out_status_ff  <= out_status_in;
      out_granted_ff <= out_granted_in;
      out_free_ff    <= out_free_in;
      out_total_ff   <= out_total_in;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_status_ff;
   assign rsp_chan.granted_address = out_granted_ff;
   assign rsp_chan.free_blocks     = out_free_ff;
   assign rsp_chan.total_blocks    = out_total_ff;

endmodule

>>> sv/fbpa_checker.sv
// port-level checks of the fixed block pool allocator, attached by bind
// depends on fbpa_pkg and fixed_block_pool_allocator_core

module fbpa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       rsp_status,
   input logic [fbpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   input logic [fbpa_pkg::COUNT_W-1:0]     rsp_free_blocks,
   input logic [fbpa_pkg::COUNT_W-1:0]     rsp_total_blocks,
   input logic                             csr_write_enable,
   input logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index
);
   import fbpa_pkg::*;

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a write to a used register rebuilds the list and blocks requests
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && (csr_index == CSR_POOL_BASE || csr_index == CSR_BLOCK_SIZE ||
                            csr_index == CSR_BLOCK_COUNT)) |=> !req_ready)
      else $error("request accepted right after a register write");

   // free count never exceeds the pool size, and empty means none free
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_blocks <= rsp_total_blocks) &&
                    (rsp_status != ST_EMPTY || rsp_free_blocks == '0))
      else $error("inconsistent block counts");

   // no address granted on a failed transaction
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_granted_address == '0)
      else $error("address granted on a failed transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_granted_address) && $stable(rsp_free_blocks) &&
         $stable(rsp_total_blocks))
      else $error("stalled response changed");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_status          (rsp_chan.status),
   .rsp_granted_address (rsp_chan.granted_address),
   .rsp_free_blocks     (rsp_chan.free_blocks),
   .rsp_total_blocks    (rsp_chan.total_blocks),
   .csr_write_enable    (csr_write_enable),
   .csr_index           (csr_index)
);

>>> bench/fixed_block_pool_allocator_core_tb.sv
// testbench for fixed_block_pool_allocator_core: directed table, then randomized phases
// checked against a free-list predictor; needs fbpa_pkg, fbpa_if and the core's rtl
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core_tb;
   import fbpa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 500;
   localparam int RUN_PHASES    = 9;
   localparam int PHASE_ITEMS   = 120;

   typedef struct packed {
      status_type         st;
      logic [ADDR_W-1:0]  grant;
      logic [COUNT_W-1:0] nfree;
      logic [COUNT_W-1:0] ntotal;
   } outcome_type;

   typedef struct packed {
      logic                 is_reg;
      logic [CSR_IDX_W-1:0] reg_sel;
      logic [ADDR_W-1:0]    reg_val;
      req_kind_type         kind;
      logic [ADDR_W-1:0]    addr;
      logic                 typed;
      outcome_type          want;
   } step_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_write_data;
   int                   errors = 0;
   bit                   hold_rsp = 1'b0;

   fbpa_req_if req_bus ();
   fbpa_rsp_if rsp_bus ();

   fixed_block_pool_allocator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // free list predictor state
   logic [COUNT_W-1:0] succ_of [0:MAX_BLOCKS-1];
   logic [COUNT_W-1:0] top_block;
   logic [COUNT_W-1:0] blocks_free;
   logic [ADDR_W-1:0]  base_reg;
   logic [SIZE_W-1:0]  size_reg;
   logic [COUNT_W-1:0] count_reg;

   outcome_type pending_outcomes [$];

   step_row_type script [34] = '{
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_OK, 32'h1000, 11'd1023, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_OK, 32'h1008, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0, 1'b1,
        '{ST_NULL, 32'h0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_0FFF, 1'b1,
        '{ST_BAD, 32'h0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_1004, 1'b1,
        '{ST_BAD, 32'h0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_3000, 1'b1,
        '{ST_BAD, 32'h0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'hFFFF_FFFF, 1'b1,
        '{ST_BAD, 32'h0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_1008, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_1008, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_2FF8, 1'b0, '0},
      '{1'b1, CSR_BLOCK_COUNT, 32'hFFFF_F800, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_OK, 32'h1000, 11'd0, 11'd1}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_EMPTY, 32'h0, 11'd0, 11'd1}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_1008, 1'b1,
        '{ST_BAD, 32'h0, 11'd0, 11'd1}},
      '{1'b1, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0, 1'b1,
        '{ST_NULL, 32'h0, 11'd1, 11'd1}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_OK, 32'h0, 11'd0, 11'd1}},
      '{1'b1, CSR_BLOCK_SIZE, 32'hFFFE_0003, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b1, CSR_BLOCK_COUNT, 32'h0000_07FF, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_0008, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b1, CSR_POOL_BASE, 32'hFFFF_FFF0, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b1, CSR_BLOCK_SIZE, 32'h0001_0000, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_OK, 32'hFFFF_FFF0, 11'd1023, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b1,
        '{ST_OK, 32'h0000_FFF0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_FFF0, 1'b1,
        '{ST_BAD, 32'h0, 11'd1022, 11'd1024}},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'hFFFF_FFF0, 1'b0, '0},
      '{1'b1, CSR_UNUSED, 32'hA5A5_A5A5, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b1, CSR_POOL_BASE, 32'h0000_0064, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b1, CSR_BLOCK_SIZE, 32'h0000_0018, REQ_ALLOC, 32'h0, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_00DC, 1'b0, '0},
      '{1'b0, CSR_POOL_BASE, 32'h0, REQ_FREE, 32'h0000_00E4, 1'b0, '0}
   };

   function automatic logic [SIZE_W-1:0] block_bytes();
      return (size_reg < LINK_WORD_BYTES) ? LINK_WORD_BYTES : size_reg;
   endfunction

   function automatic logic [COUNT_W-1:0] usable_blocks();
      if (count_reg == 0) return 11'd1;
      if (count_reg > MAX_BLOCKS) return 11'(MAX_BLOCKS);
      return count_reg;
   endfunction

   function automatic void relink();
      logic [COUNT_W-1:0] n;
      n = usable_blocks();
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         succ_of[i] = (i + 1 < n) ? 11'(i + 1) : 11'd0;
      end
      top_block   = 11'd0;
      blocks_free = n;
   endfunction

   function automatic outcome_type pool_outcome(input req_kind_type kind,
                                                input logic [ADDR_W-1:0] addr);
      outcome_type       o;
      logic [ADDR_W-1:0] n32;
      logic [ADDR_W-1:0] bs32;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] slot;
      n32  = 32'(usable_blocks());
      bs32 = 32'(block_bytes());
      o    = '0;
      o.st = ST_OK;
      if (kind == REQ_ALLOC) begin
         if (blocks_free == 0) begin
            o.st = ST_EMPTY;
         end else begin
            o.grant     = base_reg + 32'(top_block) * bs32;
            top_block   = succ_of[top_block];
            blocks_free = blocks_free - 11'd1;
         end
      end else if (addr == 0) begin
         o.st = ST_NULL;
      end else if (addr < base_reg) begin
         o.st = ST_BAD;
      end else begin
         off  = addr - base_reg;
         slot = off / bs32;
         if (off % bs32 != 0 || slot >= n32) begin
            o.st = ST_BAD;
         end else begin
            succ_of[slot] = top_block;
            top_block     = slot[COUNT_W-1:0];
            // double free pushes again, count saturates
            if (32'(blocks_free) < n32) blocks_free = blocks_free + 11'd1;
         end
      end
      o.nfree  = blocks_free;
      o.ntotal = n32[COUNT_W-1:0];
      return o;
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel, input logic [ADDR_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (sel)
         CSR_POOL_BASE:   base_reg  = val;
         CSR_BLOCK_SIZE:  size_reg  = val[SIZE_W-1:0];
         CSR_BLOCK_COUNT: count_reg = val[COUNT_W-1:0];
         default: ;
      endcase
      if (sel != CSR_UNUSED) relink();
   endtask

   task automatic send_req(input req_kind_type kind, input logic [ADDR_W-1:0] addr,
                           output outcome_type res);
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.block_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      res = pool_outcome(kind, addr);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("** fixed_block_pool_allocator_core: FAILED **");
      $finish;
   end

   // response side stall pattern
   initial begin
      int unsigned run_left;
      int          mode;
      run_left = 0;
      mode     = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (run_left == 0) begin
            mode     = $urandom_range(0, 3);
            run_left = $urandom_range(5, 80);
         end
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         endcase
         run_left--;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            flag_error("response transaction with nothing outstanding");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.status !== want.st)
               flag_error($sformatf("status got %0d want %0d", rsp_bus.status, want.st));
            if (rsp_bus.granted_address !== want.grant)
               flag_error($sformatf("granted_address got %h want %h",
                                    rsp_bus.granted_address, want.grant));
            if (rsp_bus.free_blocks !== want.nfree)
               flag_error($sformatf("free_blocks got %0d want %0d",
                                    rsp_bus.free_blocks, want.nfree));
            if (rsp_bus.total_blocks !== want.ntotal)
               flag_error($sformatf("total_blocks got %0d want %0d",
                                    rsp_bus.total_blocks, want.ntotal));
         end
      end
   end

   initial begin
      outcome_type       res;
      logic [ADDR_W-1:0] held [$];
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] val;
      logic [ADDR_W-1:0] bs32;
      logic [ADDR_W-1:0] n32;
      req_kind_type      kind;
      int                burst_left;
      int                alloc_pct;
      int                pick;
      int                s;
      int                j;

      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_POOL_BASE;
      csr_write_data        <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_ALLOC;
      req_bus.block_address <= '0;
      base_reg  = POOL_BASE_RST;
      size_reg  = BLOCK_SIZE_RST;
      count_reg = BLOCK_COUNT_RST;
      relink();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_reg) begin
            wait_idle();
            write_reg(script[k].reg_sel, script[k].reg_val);
         end else begin
            send_req(script[k].kind, script[k].addr, res);
            pending_outcomes.push_back(script[k].typed ? script[k].want : res);
         end
      end

      burst_left = $urandom_range(1, 40);
      for (int phase = 0; phase < RUN_PHASES; phase++) begin
         wait_idle();
         pick = (phase < 6) ? phase : $urandom_range(0, 5);
         case (pick % 5)
            0:       val = 32'h1;
            1:       val = 32'hFFFF_FFFF;
            2:       val = $urandom();
            3:       val = $urandom_range(1, 32'hFFFF);
            default: val = POOL_BASE_RST;
         endcase
         write_reg(CSR_POOL_BASE, val);
         case (pick)
            0:       val = $urandom_range(0, 7);
            1:       val = 32'd8;
            2:       val = 32'd65536;
            3:       val = 32'h1_FFFF;
            4:       val = $urandom_range(9, 64);
            default: val = $urandom_range(8, 65536);
         endcase
         write_reg(CSR_BLOCK_SIZE, ($urandom() & 32'hFFFE_0000) | val);
         case ((pick + 2) % 6)
            0:       val = 32'd0;
            1:       val = 32'd1;
            2:       val = $urandom_range(2, 16);
            3:       val = 32'd1024;
            4:       val = $urandom_range(1025, 2047);
            default: val = $urandom_range(17, 1024);
         endcase
         write_reg(CSR_BLOCK_COUNT, ($urandom() & 32'hFFFF_F800) | val);
         if (phase % 3 == 1) write_reg(CSR_UNUSED, $urandom());
         held.delete();
         alloc_pct = $urandom_range(25, 70);
         bs32 = 32'(block_bytes());
         n32  = 32'(usable_blocks());
         if (phase == 2 || phase == 6) hold_rsp = 1'b1;

         repeat (PHASE_ITEMS) begin
            addr = $urandom();
            if ($urandom_range(0, 99) < alloc_pct) begin
               kind = REQ_ALLOC;
            end else begin
               kind = REQ_FREE;
               s    = $urandom_range(0, 19);
               if (s < 12 && held.size() != 0) begin
                  j    = $urandom_range(0, held.size() - 1);
                  addr = held[j];
                  held.delete(j);
               end else if (s <= 12) begin
                  // any block in the pool, often one already free
                  addr = base_reg + 32'($urandom_range(0, n32 - 1)) * bs32;
               end else if (s == 13) begin
                  addr = '0;
               end else if (s == 14) begin
                  addr = base_reg + 32'($urandom_range(0, n32 - 1)) * bs32
                         + 32'($urandom_range(1, bs32 - 1));
               end else if (s == 15) begin
                  addr = base_reg + (n32 + 32'($urandom_range(0, 3))) * bs32;
               end else if (s == 16 && base_reg > 1) begin
                  addr = $urandom_range(1, base_reg - 1);
               end
            end
            send_req(kind, addr, res);
            pending_outcomes.push_back(res);
            if (kind == REQ_ALLOC && res.st == ST_OK) held.push_back(res.grant);
            burst_left--;
            if (burst_left == 0) begin
               req_bus.valid <= 1'b0;
               repeat ($urandom_range(1, 25)) @(posedge clock);
               burst_left = $urandom_range(1, 40);
            end
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("** fixed_block_pool_allocator_core: PASSED **");
      end else begin
         $display("** fixed_block_pool_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
sv/fbpa_pkg.sv
sv/fbpa_if.sv
sv/fbpa_ram.sv
sv/fbpa_div.sv
sv/fixed_block_pool_allocator_core.sv
sv/fbpa_checker.sv
bench/fixed_block_pool_allocator_core_tb.sv
